// ----- hdl/lru_pool_with_pinned_entry_defines.svh -----
// Assertion macros for the pool checker.
`ifndef LRU_POOL_WITH_PINNED_ENTRY_DEFINES_SVH
`define LRU_POOL_WITH_PINNED_ENTRY_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LRUP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LRUP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/lrup_pkg.sv -----
package lrup_pkg;

	localparam int MAX_SLOTS_DEF = 8;
	localparam int ID_BITS_DEF   = 16;
	localparam int ME_W          = 4;
	localparam int ME_LIMIT      = 8;
	localparam int ME_RESET      = 8;
	localparam int KIND_W        = 3;
	localparam int OP_W          = 2;
	localparam int CFG_IDX_W     = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ACTIVATE = 2'd0,
		OP_STOP     = 2'd1,
		OP_RECHECK  = 2'd2,
		OP_STOP_ALL = 2'd3
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		K_HIT      = 3'd0,
		K_SPAWNED  = 3'd1,
		K_EVICTED  = 3'd2,
		K_REJECTED = 3'd3,
		K_DONE     = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_ENTRIES = 2'd0,
		CFG_PINNED_ID   = 2'd1,
		CFG_TOOL_PATH   = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ID_REQ,
		ID_VICTIM,
		ID_ZERO
	} idsel_t;

	typedef enum logic {
		RM_SCAN,
		RM_VICTIM
	} rmsel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_HIT_RM,
		ST_HIT_APP,
		ST_EVICT,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic   capture;
		logic   scan_next;
		logic   remove;
		rmsel_t rm_sel;
		logic   append;
		logic   clear;
		logic   emit;
		kind_t  emit_kind;
		idsel_t emit_id;
		logic   emit_last;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic id_zero;
		logic tool_set;
		logic at_end;
		logic match;
		logic full;
		logic over;
		logic gone;
		logic out_free;
	} sts_t;

endpackage

// ----- hdl/lrup_if.sv -----
interface lrup_req_if #(
	parameter int ID_BITS = lrup_pkg::ID_BITS_DEF
);
	logic                       valid;
	logic                       ready;
	logic [lrup_pkg::OP_W-1:0]  op;
	logic [ID_BITS-1:0]         project_id;

	modport source(output valid, output op, output project_id, input ready);
	modport sink(input valid, input op, input project_id, output ready);
endinterface

interface lrup_rsp_if #(
	parameter int ID_BITS = lrup_pkg::ID_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic [lrup_pkg::KIND_W-1:0]  kind;
	logic [ID_BITS-1:0]           result_id;
	logic                         last;

	modport source(output valid, output kind, output result_id, output last, input ready);
	modport sink(input valid, input kind, input result_id, input last, output ready);
endinterface

// ----- hdl/lrup_dp.sv -----
module lrup_dp #(
	parameter int MAX_SLOTS = lrup_pkg::MAX_SLOTS_DEF,
	parameter int ID_BITS   = lrup_pkg::ID_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lrup_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [ID_BITS-1:0]             cfg_data,
	input  logic [lrup_pkg::OP_W-1:0]      req_op,
	input  logic [ID_BITS-1:0]             req_id,
	input  lrup_pkg::cmd_t                 cmd,
	output lrup_pkg::sts_t                 sts,
	input  logic                           rsp_ready,
	output logic                           rsp_valid,
	output logic [lrup_pkg::KIND_W-1:0]    rsp_kind,
	output logic [ID_BITS-1:0]             rsp_id,
	output logic                           rsp_last
);

	localparam int DEPTH = MAX_SLOTS + 1;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CAP   = (MAX_SLOTS < lrup_pkg::ME_LIMIT) ? MAX_SLOTS : lrup_pkg::ME_LIMIT;
	localparam int CMP_W = (CNT_W > lrup_pkg::ME_W) ? CNT_W : lrup_pkg::ME_W;

	logic [ID_BITS-1:0]        slots_q [DEPTH];
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          idx_q;
	lrup_pkg::op_t             op_q;
	logic [ID_BITS-1:0]        id_q;
	logic                      gone_q;
	logic [lrup_pkg::ME_W-1:0] me_q;
	logic [ID_BITS-1:0]        pinned_q;
	logic                      tool_q;
	logic                      rsp_valid_q;
	lrup_pkg::kind_t           rsp_kind_q;
	logic [ID_BITS-1:0]        rsp_id_q;
	logic                      rsp_last_q;

	logic                      at_end;
	logic [ID_BITS-1:0]        scan_id;
	logic [IDX_W-1:0]          victim_idx;
	logic [ID_BITS-1:0]        victim_id;
	logic [IDX_W-1:0]          rm_idx;
	logic                      out_free;
	logic                      out_load;
	logic [ID_BITS-1:0]        emit_id;
	logic [lrup_pkg::ME_W-1:0] me_raw;
	logic [lrup_pkg::ME_W-1:0] me_clamped;

	assign at_end     = idx_q >= count_q;
	assign scan_id    = slots_q[idx_q[IDX_W-1:0]];
	assign victim_idx = (slots_q[0] == pinned_q) ? IDX_W'(1) : '0;
	assign victim_id  = slots_q[victim_idx];
	assign rm_idx     = (cmd.rm_sel == lrup_pkg::RM_SCAN) ? idx_q[IDX_W-1:0] : victim_idx;
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign out_load   = cmd.emit && out_free;
	assign me_raw     = cfg_data[lrup_pkg::ME_W-1:0];

	always_comb begin
		if (me_raw == '0) begin
			me_clamped = lrup_pkg::ME_W'(1);
		end else if (me_raw > lrup_pkg::ME_W'(CAP)) begin
			me_clamped = lrup_pkg::ME_W'(CAP);
		end else begin
			me_clamped = me_raw;
		end
	end

	always_comb begin
		case (cmd.emit_id)
			lrup_pkg::ID_REQ:    emit_id = id_q;
			lrup_pkg::ID_VICTIM: emit_id = victim_id;
			lrup_pkg::ID_ZERO:   emit_id = '0;
			default:             emit_id = '0;
		endcase
	end

	always_comb begin
		sts.op       = op_q;
		sts.id_zero  = id_q == '0;
		sts.tool_set = tool_q;
		sts.at_end   = at_end;
		sts.match    = !at_end && (scan_id == id_q);
		sts.full     = count_q > CNT_W'(MAX_SLOTS);
		sts.over     = CMP_W'(count_q) > CMP_W'(me_q);
		sts.gone     = gone_q;
		sts.out_free = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			me_q     <= lrup_pkg::ME_W'(CAP < lrup_pkg::ME_RESET ? CAP : lrup_pkg::ME_RESET);
			pinned_q <= '0;
			tool_q   <= 1'b0;
		end else if (cfg_we) begin
			case (lrup_pkg::cfg_idx_t'(cfg_idx))
				lrup_pkg::CFG_MAX_ENTRIES: me_q <= me_clamped;
				lrup_pkg::CFG_PINNED_ID:   pinned_q <= cfg_data;
				lrup_pkg::CFG_TOOL_PATH:   tool_q <= cfg_data[0];
				default:                   ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.remove) begin
			for (int j = 0; j < DEPTH - 1; j++) begin
				if (IDX_W'(j) >= rm_idx) begin
					slots_q[j] <= slots_q[j+1];
				end
			end
		end else if (cmd.append) begin
			slots_q[count_q[IDX_W-1:0]] <= id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.remove) begin
			count_q <= count_q - CNT_W'(1);
		end else if (cmd.append) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			gone_q <= 1'b0;
		end else if (cmd.capture) begin
			idx_q  <= '0;
			gone_q <= 1'b0;
		end else begin
			if (cmd.scan_next) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.remove && cmd.rm_sel == lrup_pkg::RM_VICTIM && victim_id == id_q) begin
				gone_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= lrup_pkg::op_t'(req_op);
			id_q <= req_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_kind_q <= cmd.emit_kind;
			rsp_id_q   <= emit_id;
			rsp_last_q <= cmd.emit_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_kind  = rsp_kind_q;
	assign rsp_id    = rsp_id_q;
	assign rsp_last  = rsp_last_q;

endmodule

// ----- hdl/lrup_ctrl.sv -----
module lrup_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  lrup_pkg::sts_t sts,
	output lrup_pkg::cmd_t cmd
);

	lrup_pkg::state_t state_q, state_d;
	lrup_pkg::kind_t  rkind_q, rkind_d;
	logic             rzero_q, rzero_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrup_pkg::ST_IDLE;
			rkind_q <= lrup_pkg::K_DONE;
			rzero_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rkind_q <= rkind_d;
			rzero_q <= rzero_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		rkind_d       = rkind_q;
		rzero_d       = rzero_q;
		req_ready     = 1'b0;
		cmd           = '0;
		cmd.rm_sel    = lrup_pkg::RM_SCAN;
		cmd.emit_kind = rkind_q;
		cmd.emit_id   = lrup_pkg::ID_REQ;
		case (state_q)
			lrup_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = lrup_pkg::ST_DISPATCH;
				end
			end
			lrup_pkg::ST_DISPATCH: begin
				rzero_d = 1'b0;
				case (sts.op)
					lrup_pkg::OP_ACTIVATE: begin
						if (sts.id_zero || !sts.tool_set) begin
							rkind_d = lrup_pkg::K_REJECTED;
							state_d = lrup_pkg::ST_REPORT;
						end else begin
							state_d = lrup_pkg::ST_SCAN;
						end
					end
					lrup_pkg::OP_STOP: begin
						if (sts.id_zero) begin
							rkind_d = lrup_pkg::K_DONE;
							state_d = lrup_pkg::ST_REPORT;
						end else begin
							state_d = lrup_pkg::ST_SCAN;
						end
					end
					lrup_pkg::OP_RECHECK: begin
						state_d = lrup_pkg::ST_EVICT;
					end
					default: begin
						cmd.clear = 1'b1;
						rkind_d   = lrup_pkg::K_DONE;
						rzero_d   = 1'b1;
						state_d   = lrup_pkg::ST_REPORT;
					end
				endcase
			end
			lrup_pkg::ST_SCAN: begin
				if (sts.at_end) begin
					if (sts.op != lrup_pkg::OP_ACTIVATE) begin
						rkind_d = lrup_pkg::K_DONE;
						state_d = lrup_pkg::ST_REPORT;
					end else if (sts.full) begin
						rkind_d = lrup_pkg::K_REJECTED;
						state_d = lrup_pkg::ST_REPORT;
					end else begin
						cmd.append = 1'b1;
						state_d    = lrup_pkg::ST_EVICT;
					end
				end else if (sts.match) begin
					if (sts.op == lrup_pkg::OP_ACTIVATE) begin
						state_d = lrup_pkg::ST_HIT_RM;
					end else begin
						cmd.remove = 1'b1;
						rkind_d    = lrup_pkg::K_EVICTED;
						state_d    = lrup_pkg::ST_REPORT;
					end
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			lrup_pkg::ST_HIT_RM: begin
				cmd.remove = 1'b1;
				state_d    = lrup_pkg::ST_HIT_APP;
			end
			lrup_pkg::ST_HIT_APP: begin
				cmd.append = 1'b1;
				rkind_d    = lrup_pkg::K_HIT;
				state_d    = lrup_pkg::ST_REPORT;
			end
			lrup_pkg::ST_EVICT: begin
				if (sts.over) begin
					cmd.emit_kind = lrup_pkg::K_EVICTED;
					cmd.emit_id   = lrup_pkg::ID_VICTIM;
					cmd.emit      = 1'b1;
					cmd.rm_sel    = lrup_pkg::RM_VICTIM;
					cmd.remove    = sts.out_free;
				end else if (sts.op == lrup_pkg::OP_ACTIVATE) begin
					rkind_d = sts.gone ? lrup_pkg::K_REJECTED : lrup_pkg::K_SPAWNED;
					state_d = lrup_pkg::ST_REPORT;
				end else begin
					rkind_d = lrup_pkg::K_DONE;
					rzero_d = 1'b1;
					state_d = lrup_pkg::ST_REPORT;
				end
			end
			lrup_pkg::ST_REPORT: begin
				cmd.emit      = 1'b1;
				cmd.emit_last = 1'b1;
				cmd.emit_id   = rzero_q ? lrup_pkg::ID_ZERO : lrup_pkg::ID_REQ;
				if (sts.out_free) begin
					state_d = lrup_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lrup_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/lru_pool_with_pinned_entry.sv -----
// Pool of up to max_entries resident IDs kept oldest first, with one pinned ID that is never
// evicted. Requests are taken one at a time: a request is accepted and is decoded in the cycle
// after; activate and stop then search the pool one slot per cycle, a hit moves the ID to the
// newest end in two steps (removal, then append), and capacity enforcement evicts one ID per
// cycle while the result side takes beats, each eviction a result beat of its own; the final
// beat is then sent from the report state. Stop all and requests rejected at decode go straight
// from decode to the final beat. A new request is taken as soon as the final beat of the
// previous one sits in the output register.
// Slot contents are not cleared at reset; only the resident count is.
module lru_pool_with_pinned_entry #(
	parameter int MAX_SLOTS = lrup_pkg::MAX_SLOTS_DEF,
	parameter int ID_BITS   = lrup_pkg::ID_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	lrup_req_if.sink                       req,
	lrup_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [lrup_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [ID_BITS-1:0]             cfg_data
);

	lrup_pkg::cmd_t cmd;
	lrup_pkg::sts_t sts;

	lrup_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lrup_dp #(
		.MAX_SLOTS (MAX_SLOTS),
		.ID_BITS   (ID_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.req_op    (req.op),
		.req_id    (req.project_id),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.rsp_kind  (rsp.kind),
		.rsp_id    (rsp.result_id),
		.rsp_last  (rsp.last)
	);

endmodule

// ----- hdl/lrup_chk.sv -----
`include "lru_pool_with_pinned_entry_defines.svh"

module lrup_chk #(
	parameter int ID_BITS = lrup_pkg::ID_BITS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [lrup_pkg::KIND_W-1:0] rsp_kind,
	input logic [ID_BITS-1:0]          rsp_result_id,
	input logic                        rsp_last
);

	`LRUP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result beat dropped")
	`LRUP_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_kind) && $stable(rsp_result_id) && $stable(rsp_last), "stalled beat changed")
	`LRUP_ASSERT_NEXT(a_one_req, req_valid && req_ready, !req_ready, "request taken while busy")
	`LRUP_ASSERT_NOW(a_final_kind, rsp_valid && (rsp_kind == lrup_pkg::K_HIT || rsp_kind == lrup_pkg::K_SPAWNED || rsp_kind == lrup_pkg::K_REJECTED || rsp_kind == lrup_pkg::K_DONE), rsp_last, "final kind without last")

endmodule

bind lru_pool_with_pinned_entry lrup_chk #(
	.ID_BITS (ID_BITS)
) u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_kind      (rsp.kind),
	.rsp_result_id (rsp.result_id),
	.rsp_last      (rsp.last)
);
